@@ hw/rtl/lant_pkg.sv @@
// ----------------------------------------------------------------------------
// lant_pkg
// Shared types and constants for the ant stepper: register map, reset values,
// heading and action codes, controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package lant_pkg;

	// register map, index taken from paddr[2]
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// register widths and reset values
	localparam int unsigned GW_BITS = 7;
	localparam int unsigned GH_BITS = 6;
	localparam logic [GW_BITS-1:0] GRID_WIDTH_RST  = 7'd64;
	localparam logic [GH_BITS-1:0] GRID_HEIGHT_RST = 6'd32;

	// ant start position after reset
	localparam int unsigned START_COL = 35;
	localparam int unsigned START_ROW = 18;

	// payload port widths
	localparam int unsigned PX_BITS = 6;
	localparam int unsigned PY_BITS = 5;

	// action codes
	localparam logic ACT_STEP  = 1'b0;
	localparam logic ACT_PLACE = 1'b1;

	// heading codes
	localparam logic [1:0] HEAD_NORTH = 2'd0;
	localparam logic [1:0] HEAD_EAST  = 2'd1;
	localparam logic [1:0] HEAD_SOUTH = 2'd2;
	localparam logic [1:0] HEAD_WEST  = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic clear;   // clearing pass, one cell per cycle
		logic issue;   // item taken: grid write on a step, grid read and position update
		logic finish;  // grid read data back: heading update and result capture
	} lant_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_last;  // last cell of the clearing pass
	} lant_status_t;

endpackage

@@ hw/rtl/lant_ctrl.sv @@
// ----------------------------------------------------------------------------
// lant_ctrl
// Controller: clearing pass after reset, item acceptance, result strobe.
// ----------------------------------------------------------------------------
module lant_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lant_pkg::lant_status_t status,
	output lant_pkg::lant_cmd_t    cmd,
	output logic                  busy,
	output logic                  done
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   done_q;

	// commands to the datapath
	always_comb begin
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.issue  = (state_q == ST_IDLE) && start;
		cmd.finish = (state_q == ST_RESP);
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RESP);
			unique case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) state_q <= ST_RESP;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

@@ hw/rtl/lant_datapath.sv @@
// ----------------------------------------------------------------------------
// lant_datapath
// Grid memory, ant position and heading, wrap logic and result registers.
// ----------------------------------------------------------------------------
module lant_datapath #(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lant_pkg::lant_cmd_t                cmd,
	output lant_pkg::lant_status_t             status,
	input  logic [lant_pkg::GW_BITS-1:0]       grid_width,
	input  logic [lant_pkg::GH_BITS-1:0]       grid_height,
	input  logic                              action,
	input  logic [lant_pkg::PX_BITS-1:0]       place_x,
	input  logic [lant_pkg::PY_BITS-1:0]       place_y,
	output logic                              accepted,
	output logic [5:0]                        ant_col,
	output logic [4:0]                        ant_row,
	output logic [1:0]                        heading,
	output logic                              cell_left_value,
	output logic                              cell_here_value
);

	localparam int unsigned CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned AW = CW + RW;
	localparam int unsigned DEPTH = 1 << AW;
	// compare widths: wide enough for the register and for the limit itself
	localparam int unsigned WW = (CW + 1 > lant_pkg::GW_BITS) ? CW + 1 : lant_pkg::GW_BITS;
	localparam int unsigned HW = (RW + 1 > lant_pkg::GH_BITS) ? RW + 1 : lant_pkg::GH_BITS;
	localparam int unsigned COL_RST = (lant_pkg::START_COL < MAX_COLS) ? lant_pkg::START_COL : 0;
	localparam int unsigned ROW_RST = (lant_pkg::START_ROW < MAX_ROWS) ? lant_pkg::START_ROW : 0;

	// grid memory, one bit per cell, address {row, col}
	logic          grid_mem [DEPTH];
	logic          rd_q;

	logic [CW-1:0] pos_col_q;
	logic [RW-1:0] pos_row_q;
	logic [1:0]    facing_q;
	logic          here_q;
	logic          step_q;
	logic          acc_q;
	logic          left_q;
	logic [AW-1:0] clr_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [WW-1:0] col_ext;
	logic [HW-1:0] row_ext;
	logic [WW-1:0] px_ext;
	logic [HW-1:0] py_ext;
	logic          is_step;
	logic          place_ok;
	logic [CW-1:0] nxt_col;
	logic [RW-1:0] nxt_row;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_wdata;

	// effective dimensions, saturated to 2..MAX
	always_comb begin
		if (grid_width < lant_pkg::GW_BITS'(2))
			w_eff = WW'(2);
		else if (WW'(grid_width) > WW'(MAX_COLS))
			w_eff = WW'(MAX_COLS);
		else
			w_eff = WW'(grid_width);
		if (grid_height < lant_pkg::GH_BITS'(2))
			h_eff = HW'(2);
		else if (HW'(grid_height) > HW'(MAX_ROWS))
			h_eff = HW'(MAX_ROWS);
		else
			h_eff = HW'(grid_height);
	end

	// next position for a step or a placement
	always_comb begin
		col_ext  = WW'(pos_col_q);
		row_ext  = HW'(pos_row_q);
		px_ext   = WW'(place_x);
		py_ext   = HW'(place_y);
		is_step  = (action == lant_pkg::ACT_STEP);
		place_ok = (px_ext < w_eff) && (py_ext < h_eff);
		nxt_col  = pos_col_q;
		nxt_row  = pos_row_q;
		if (is_step) begin
			case (facing_q)
				lant_pkg::HEAD_NORTH: begin
					nxt_row = (pos_row_q != '0) ? pos_row_q - RW'(1) : RW'(h_eff - HW'(1));
				end
				lant_pkg::HEAD_EAST: begin
					nxt_col = (col_ext + WW'(1) < w_eff) ? CW'(col_ext + WW'(1)) : '0;
				end
				lant_pkg::HEAD_SOUTH: begin
					nxt_row = (row_ext + HW'(1) < h_eff) ? RW'(row_ext + HW'(1)) : '0;
				end
				default: begin
					nxt_col = (pos_col_q != '0) ? pos_col_q - CW'(1) : CW'(w_eff - WW'(1));
				end
			endcase
		end else if (place_ok) begin
			nxt_col = CW'(px_ext);
			nxt_row = RW'(py_ext);
		end
	end

	// grid write port: clearing pass or inverting the cell left behind
	always_comb begin
		mem_we    = cmd.clear || (cmd.issue && is_step);
		mem_waddr = cmd.clear ? clr_q : {pos_row_q, pos_col_q};
		mem_wdata = cmd.clear ? 1'b0 : ~here_q;
	end

	// grid memory, write and registered read in the same cycle
	always_ff @(posedge clk) begin
		if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
		if (cmd.issue) rd_q <= grid_mem[{nxt_row, nxt_col}];
	end

	assign status.clear_last = (clr_q == {AW{1'b1}});

	// ant state and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_col_q <= CW'(COL_RST);
			pos_row_q <= RW'(ROW_RST);
			facing_q  <= lant_pkg::HEAD_NORTH;
			here_q    <= 1'b0;
			clr_q     <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + AW'(1);
			if (cmd.issue) begin
				pos_col_q <= nxt_col;
				pos_row_q <= nxt_row;
			end
			if (cmd.finish) begin
				here_q <= rd_q;
				// right turn onto an empty cell, left onto a filled one
				if (step_q) facing_q <= rd_q ? facing_q - 2'd1 : facing_q + 2'd1;
			end
		end
	end

	// per-item bookkeeping captured at acceptance
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			step_q <= is_step;
			acc_q  <= is_step || place_ok;
			left_q <= is_step ? ~here_q : 1'b0;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			accepted        <= acc_q;
			ant_col         <= 6'(pos_col_q);
			ant_row         <= 5'(pos_row_q);
			heading         <= step_q ? (rd_q ? facing_q - 2'd1 : facing_q + 2'd1) : facing_q;
			cell_left_value <= left_q;
			cell_here_value <= rd_q;
		end
	end

endmodule

@@ hw/rtl/langton_ant_step.sv @@
// ----------------------------------------------------------------------------
// langton_ant_step
// Langton's ant on a one-bit toroidal grid with a configurable wrap size.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high, after the response state,
// and cannot be held off. busy is low again in the cycle that shows done, so
// a new item can be taken in that cycle. The grid memory sets the steps: the
// acceptance cycle writes the cell left behind and reads the cell entered,
// the response state takes the registered read data to set the heading.
// After reset the grid is cleared one cell per cycle, all 2**(clog2(MAX_COLS) +
// clog2(MAX_ROWS)) cells (2048 at the defaults), with busy high; register
// writes are taken during that time.
// ----------------------------------------------------------------------------
module langton_ant_step #(
	parameter int unsigned MAX_COLS = 64,
	parameter int unsigned MAX_ROWS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [5:0]  place_x,
	input  logic [4:0]  place_y,
	// result channel
	output logic        done,
	output logic        accepted,
	output logic [5:0]  ant_col,
	output logic [4:0]  ant_row,
	output logic [1:0]  heading,
	output logic        cell_left_value,
	output logic        cell_here_value,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [lant_pkg::GW_BITS-1:0] grid_width_q;
	logic [lant_pkg::GH_BITS-1:0] grid_height_q;
	lant_pkg::lant_cmd_t           cmd;
	lant_pkg::lant_status_t        status;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lant_pkg::GRID_WIDTH_RST;
			grid_height_q <= lant_pkg::GRID_HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				lant_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[lant_pkg::GW_BITS-1:0];
				lant_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[lant_pkg::GH_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[2])
			lant_pkg::REG_GRID_WIDTH:  prdata = 32'(grid_width_q);
			lant_pkg::REG_GRID_HEIGHT: prdata = 32'(grid_height_q);
			default:                   prdata = '0;
		endcase
	end

	lant_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	lant_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.grid_width      (grid_width_q),
		.grid_height     (grid_height_q),
		.action          (action),
		.place_x         (place_x),
		.place_y         (place_y),
		.accepted        (accepted),
		.ant_col         (ant_col),
		.ant_row         (ant_row),
		.heading         (heading),
		.cell_left_value (cell_left_value),
		.cell_here_value (cell_here_value)
	);

endmodule
